>>> src/quad_mesh_panel_geometry_defines.svh
// Assertion macros for the panel geometry block.
`ifndef QUAD_MESH_PANEL_GEOMETRY_DEFINES_SVH
`define QUAD_MESH_PANEL_GEOMETRY_DEFINES_SVH
`ifndef SYNTHESIS
`define QMPG_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("qmpg check failed");
`define QMPG_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("qmpg check failed");
`else
`define QMPG_ASSERT_IMP(label, clk, rst_n, a, c)
`define QMPG_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> src/qmpg_pkg.sv
`default_nettype none
package qmpg_pkg;
  localparam int CoordW = 24;
  localparam int MaxPts = 1024;
  localparam int PtIdxW = $clog2(MaxPts);
  localparam int NormW  = 16;
  localparam int AreaW  = 51;
  localparam int TotW   = 63;
  localparam int CrossW = 2 * CoordW + 4;    // one cross component
  localparam int HalfW  = CrossW / 2;        // half of a component for squaring
  localparam int SqW    = 2 * CrossW + 2;    // sum of three squares
  localparam int RootW  = SqW / 2;

  localparam logic [1:0] CFG_PPL = 2'd0;
  localparam logic [1:0] CFG_LPM = 2'd1;
  localparam logic [1:0] CFG_INV = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_DIFF, ST_CROSS, ST_SQ, ST_SQRT,
    ST_DIV, ST_DONE, ST_OUT
  } state_t;
endpackage
`default_nettype wire

>>> src/qmpg_if.sv
`default_nettype none
interface qmpg_in_if import qmpg_pkg::*; ();
  logic valid, ready;
  logic signed [CoordW-1:0] coord_x, coord_y, coord_z;
  modport source(output valid, coord_x, coord_y, coord_z, input ready);
  modport sink(input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface qmpg_out_if import qmpg_pkg::*; ();
  logic valid, ready;
  logic signed [CoordW-1:0] centroid_x, centroid_y, centroid_z;
  logic signed [NormW-1:0] normal_x, normal_y, normal_z;
  logic [AreaW-1:0] panel_area;
  logic [TotW-1:0] total_area;
  logic zero_area;
  logic [15:0] panel_row;
  logic [9:0] panel_col;
  logic last_panel;
  modport source(output valid, centroid_x, centroid_y, centroid_z, normal_x, normal_y,
    normal_z, panel_area, total_area, zero_area, panel_row, panel_col, last_panel,
    input ready);
  modport sink(input valid, centroid_x, centroid_y, centroid_z, normal_x, normal_y,
    normal_z, panel_area, total_area, zero_area, panel_row, panel_col, last_panel,
    output ready);
endinterface

interface qmpg_cfg_if ();
  logic valid, ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/quad_mesh_panel_geometry.sv
// A point that closes no panel is stored and the block returns to idle; a panel
//   result goes through the store read, cross product, squares, 53-step square
//   root and three passes of the shared divider.
// One request at a time: a new point is accepted only while the block is idle.
// Reset (rst_n low, synchronous): counters, running total, left points, state and
//   configuration registers return to their reset values; the line store is not cleared.
`default_nettype none
`include "quad_mesh_panel_geometry_defines.svh"
module quad_mesh_panel_geometry import qmpg_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  qmpg_in_if.sink   in_ch,
  qmpg_out_if.source out_ch,
  qmpg_cfg_if.sink  cfg_ch
);
  // configuration registers
  logic [10:0] ppl_r;
  logic [15:0] lpm_r;
  logic        inv_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppl_r <= 11'd2; lpm_r <= 16'd2; inv_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_PPL: ppl_r <= cfg_ch.data[10:0];
        CFG_LPM: lpm_r <= cfg_ch.data;
        CFG_INV: inv_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // clamped limits
  logic [10:0] ppl_c;
  logic [15:0] lpm_c;
  always_comb begin
    ppl_c = ppl_r;
    if (ppl_r < 11'd2) ppl_c = 11'd2;
    if (ppl_r > 11'(MaxPts)) ppl_c = 11'(MaxPts);
    lpm_c = (lpm_r < 16'd2) ? 16'd2 : lpm_r;
  end

  // previous line store: one write port, one registered read port
  point_t line_mem [MaxPts];
  point_t rd_q;

  state_t st_r, st_nxt;
  point_t cur_r, lcur_r, lprev_r;
  logic [PtIdxW-1:0] j_r;
  logic [15:0] i_r;
  logic [TotW-1:0] acc_r;
  logic line_end_r, mesh_end_r;

  logic in_fire;
  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_fire) rd_q <= line_mem[j_r];
    if (st_r == ST_READ) line_mem[j_r] <= cur_r;
  end

  // datapath registers
  logic signed [CoordW:0] d1_r [3];
  logic signed [CoordW:0] d2_r [3];
  logic signed [CrossW-1:0] n_r [3];
  logic [1:0] k_r;
  logic [1:0] h_r;      // partial product step of one square
  logic [SqW-1:0] sq_r;
  logic [RootW-1:0] s_r;
  logic [RootW+1:0] rem_r;
  logic [5:0] bit_r;
  logic signed [CoordW+1:0] cs_r [3];
  logic [NormW-1:0] q_r [3];
  logic [CrossW+14-1:0] dvd_r;
  logic [RootW:0] drem_r;
  logic [6:0] dcnt_r;
  logic panel_r;
  logic sub_phase_r;    // first or second product of a component
  logic signed [2*CoordW+1:0] p0_r;

  // shared multiplier, one product per cycle
  logic signed [CoordW:0] ma, mb;
  logic signed [2*CoordW+1:0] prod;
  always_comb begin
    ma = '0; mb = '0;
    case (k_r)
      2'd0: begin
        ma = sub_phase_r ? d1_r[2] : d1_r[1];
        mb = sub_phase_r ? d2_r[1] : d2_r[2];
      end
      2'd1: begin
        ma = sub_phase_r ? d1_r[0] : d1_r[2];
        mb = sub_phase_r ? d2_r[2] : d2_r[0];
      end
      2'd2: begin
        ma = sub_phase_r ? d1_r[1] : d1_r[0];
        mb = sub_phase_r ? d2_r[0] : d2_r[1];
      end
      default: ;
    endcase
    prod = ma * mb;
  end

  // square: three half-width partial products per component
  logic [CrossW-1:0] mag_k;
  logic [HalfW-1:0] sqa, sqb;
  logic [2*HalfW-1:0] pp;
  logic [SqW-1:0] sq_k;
  always_comb begin
    mag_k = n_r[k_r][CrossW-1] ? CrossW'(-n_r[k_r]) : CrossW'(n_r[k_r]);
    case (h_r)
      2'd0: begin
        sqa = mag_k[HalfW-1:0]; sqb = mag_k[HalfW-1:0];
      end
      2'd1: begin
        sqa = mag_k[CrossW-1:HalfW]; sqb = mag_k[HalfW-1:0];
      end
      default: begin
        sqa = mag_k[CrossW-1:HalfW]; sqb = mag_k[CrossW-1:HalfW];
      end
    endcase
    pp = sqa * sqb;
    case (h_r)
      2'd0:    sq_k = SqW'(pp);
      2'd1:    sq_k = SqW'(pp) << (HalfW + 1);   // cross term counted twice
      default: sq_k = SqW'(pp) << CrossW;
    endcase
  end

  // digit-by-digit square root, two radicand bits per cycle
  logic [RootW+3:0] rem_sh, root_try, rem_dif;
  always_comb begin
    rem_sh = {rem_r, sq_r[SqW-1:SqW-2]};
    root_try = {2'b00, s_r, 2'b01};
    rem_dif = rem_sh - root_try;
  end

  // restoring divider, one quotient bit per cycle
  logic [CrossW-1:0] dmag;
  logic [RootW+1:0] dtry;
  always_comb begin
    dmag = n_r[k_r][CrossW-1] ? CrossW'(-n_r[k_r]) : CrossW'(n_r[k_r]);
    dtry = {drem_r, dvd_r[CrossW+13]};
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (in_fire) st_nxt = ST_READ;
      ST_READ:  st_nxt = panel_r ? ST_DIFF : ST_IDLE;
      ST_DIFF:  st_nxt = ST_CROSS;
      ST_CROSS: if (k_r == 2'd2 && sub_phase_r) st_nxt = ST_SQ;
      ST_SQ:    if (k_r == 2'd2 && h_r == 2'd2) st_nxt = ST_SQRT;
      ST_SQRT:  if (bit_r == 6'd0) st_nxt = ST_DIV;
      ST_DIV:   if (k_r == 2'd2 && dcnt_r == 7'(CrossW + 14)) st_nxt = ST_DONE;
      ST_DONE:  st_nxt = ST_OUT;
      ST_OUT:   if (out_ch.ready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  logic [AreaW-1:0] area;
  logic [TotW:0] tot_sum;
  always_comb begin
    area = AreaW'(s_r >> 1);
    tot_sum = {1'b0, acc_r} + (TotW+1)'(area);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      j_r <= '0; i_r <= '0; acc_r <= '0;
      lcur_r <= '0; lprev_r <= '0;
      k_r <= '0; h_r <= '0; sub_phase_r <= 1'b0; panel_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: if (in_fire) begin
          cur_r <= '{x: in_ch.coord_x, y: in_ch.coord_y, z: in_ch.coord_z};
          panel_r <= (i_r != 16'd0) && (j_r != '0);
          line_end_r <= ({1'b0, j_r} >= ppl_c - 11'd1);
          mesh_end_r <= ({1'b0, j_r} >= ppl_c - 11'd1) && (i_r >= lpm_c - 16'd1);
        end
        ST_READ: begin
          // centroid and diagonals need lprev/lcur before they move on
          cs_r[0] <= ((CoordW+2)'(lprev_r.x) + (CoordW+2)'(rd_q.x) + (CoordW+2)'(lcur_r.x)
                     + (CoordW+2)'(cur_r.x)) >>> 2;
          cs_r[1] <= ((CoordW+2)'(lprev_r.y) + (CoordW+2)'(rd_q.y) + (CoordW+2)'(lcur_r.y)
                     + (CoordW+2)'(cur_r.y)) >>> 2;
          cs_r[2] <= ((CoordW+2)'(lprev_r.z) + (CoordW+2)'(rd_q.z) + (CoordW+2)'(lcur_r.z)
                     + (CoordW+2)'(cur_r.z)) >>> 2;
          d1_r[0] <= (CoordW+1)'(cur_r.x) - (CoordW+1)'(lprev_r.x);
          d1_r[1] <= (CoordW+1)'(cur_r.y) - (CoordW+1)'(lprev_r.y);
          d1_r[2] <= (CoordW+1)'(cur_r.z) - (CoordW+1)'(lprev_r.z);
          d2_r[0] <= (CoordW+1)'(lcur_r.x) - (CoordW+1)'(rd_q.x);
          d2_r[1] <= (CoordW+1)'(lcur_r.y) - (CoordW+1)'(rd_q.y);
          d2_r[2] <= (CoordW+1)'(lcur_r.z) - (CoordW+1)'(rd_q.z);
          lprev_r <= rd_q;
          lcur_r <= cur_r;
          if (mesh_end_r) begin
            j_r <= '0; i_r <= '0;
          end else if (line_end_r) begin
            j_r <= '0; i_r <= i_r + 16'd1;
          end else begin
            j_r <= j_r + PtIdxW'(1);
          end
          k_r <= '0; h_r <= '0; sub_phase_r <= 1'b0;
        end
        ST_DIFF: ;
        ST_CROSS: begin
          if (!sub_phase_r) begin
            p0_r <= prod; sub_phase_r <= 1'b1;
          end else begin
            n_r[k_r] <= CrossW'(p0_r) - CrossW'(prod);
            sub_phase_r <= 1'b0;
            k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
            sq_r <= '0;
          end
        end
        ST_SQ: begin
          sq_r <= sq_r + sq_k;
          if (h_r == 2'd2) begin
            h_r <= 2'd0;
            k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
          end else begin
            h_r <= h_r + 2'd1;
          end
          s_r <= '0; rem_r <= '0; bit_r <= 6'(RootW - 1);
        end
        ST_SQRT: begin
          if (rem_sh >= root_try) begin
            rem_r <= (RootW+2)'(rem_dif);
            s_r <= {s_r[RootW-2:0], 1'b1};
          end else begin
            rem_r <= (RootW+2)'(rem_sh);
            s_r <= {s_r[RootW-2:0], 1'b0};
          end
          sq_r <= sq_r << 2;
          bit_r <= bit_r - 6'd1;
          dcnt_r <= '0; drem_r <= '0;
          dvd_r <= {dmag, 14'd0};
        end
        ST_DIV: begin
          if (dcnt_r == 7'(CrossW + 14)) begin
            // quotient complete
            q_r[k_r] <= (s_r == '0) ? '0 :
              ((n_r[k_r][CrossW-1] ^ inv_r) ? NormW'(-dvd_r) : NormW'(dvd_r));
            k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
            dcnt_r <= '0; drem_r <= '0;
            dvd_r <= {(n_r[(k_r == 2'd2) ? 2'd0 : k_r + 2'd1][CrossW-1] ?
              CrossW'(-n_r[(k_r == 2'd2) ? 2'd0 : k_r + 2'd1]) :
              CrossW'(n_r[(k_r == 2'd2) ? 2'd0 : k_r + 2'd1])), 14'd0};
          end else begin
            dcnt_r <= dcnt_r + 7'd1;
            if (s_r != '0 && dtry >= {2'b0, s_r}) begin
              drem_r <= (RootW+1)'(dtry - {2'b0, s_r});
              dvd_r <= {dvd_r[CrossW+12:0], 1'b1};
            end else begin
              drem_r <= (RootW+1)'(dtry);
              dvd_r <= {dvd_r[CrossW+12:0], 1'b0};
            end
          end
        end
        ST_DONE: begin
          acc_r <= tot_sum[TotW] ? {TotW{1'b1}} : tot_sum[TotW-1:0];
        end
        ST_OUT: if (out_ch.ready && mesh_end_r) acc_r <= '0;
        default: ;
      endcase
    end
  end

  // outputs
  logic [15:0] row_r;
  logic [9:0] col_r;
  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_r <= i_r - 16'd1;
      col_r <= 10'(j_r - PtIdxW'(1));
    end
  end

  assign out_ch.valid      = (st_r == ST_OUT);
  assign out_ch.centroid_x = CoordW'(cs_r[0]);
  assign out_ch.centroid_y = CoordW'(cs_r[1]);
  assign out_ch.centroid_z = CoordW'(cs_r[2]);
  assign out_ch.normal_x   = q_r[0];
  assign out_ch.normal_y   = q_r[1];
  assign out_ch.normal_z   = q_r[2];
  assign out_ch.panel_area = area;
  assign out_ch.total_area = acc_r;
  // the floor root is zero exactly when the squared norm is zero
  assign out_ch.zero_area  = (s_r == '0);
  assign out_ch.panel_row  = row_r;
  assign out_ch.panel_col  = col_r;
  assign out_ch.last_panel = mesh_end_r;

  `QMPG_ASSERT_IMP(a_no_accept_busy, clk, rst_n, st_r != ST_IDLE, !in_ch.ready)
  `QMPG_ASSERT_NXT(a_out_after_done, clk, rst_n, st_r == ST_DONE, out_ch.valid)
  `QMPG_ASSERT_IMP(a_j_range, clk, rst_n, 1'b1, {1'b0, j_r} < ppl_c || ppl_r != ppl_c)
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none
module testbench;
  import qmpg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CoordMax = 64'sd8388607;
  localparam longint CoordMin = -64'sd8388608;
  localparam logic [62:0] TotalCap = {63{1'b1}};

  // One panel as the block reports it.
  typedef struct {
    logic signed [CoordW-1:0] cx, cy, cz;
    logic signed [NormW-1:0]  nx, ny, nz;
    logic [AreaW-1:0]         area;
    logic [TotW-1:0]          total;
    logic                     zero;
    logic [15:0]              row;
    logic [9:0]               col;
    logic                     last;
  } panel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qmpg_in_if  in_if();
  qmpg_out_if out_if();
  qmpg_cfg_if cfg_if();

  quad_mesh_panel_geometry u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("quad_mesh_panel_geometry test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  point_t point_q[$];        // requests waiting for the driver
  panel_t panel_q[$];        // predicted panels, oldest first
  int     mismatches = 0;
  bit     quiet = 1'b0;      // no random idling on either side while set
  bit     hold_go = 1'b0;    // asks the receiver for one long hold-off
  bit     hold_taken;
  int     hold_left;
  int     sent = 0;

  // Mirror of the block's registers and panel state.
  int unsigned reg_ppl, reg_lpm;
  bit          reg_inv;
  longint      line_mem [MaxPts][3];
  longint      left_cur [3];
  longint      left_prev[3];
  int unsigned pt_idx, line_idx;
  logic [62:0] area_sum;

  // ---------------------------------------------------------------------------
  // Panel predictor: runs once per accepted point, pushes a panel when the
  // point closes a quad (line >= 1, point >= 1).
  // ---------------------------------------------------------------------------
  task automatic predict_point(input point_t pt);
    longint      cur[3], prv[3], d1[3], d2[3], nv[3], csum;
    logic [63:0] mag, num, q;
    logic [127:0] sq, root, trial;
    int unsigned ppl, lpm, j, i;
    bit          line_end, mesh_end, neg;
    panel_t      p;
    ppl = reg_ppl < 2 ? 2 : (reg_ppl > MaxPts ? MaxPts : reg_ppl);
    lpm = reg_lpm < 2 ? 2 : reg_lpm;
    j = pt_idx >= MaxPts ? MaxPts - 1 : pt_idx;
    i = line_idx;
    cur[0] = pt.x; cur[1] = pt.y; cur[2] = pt.z;
    for (int k = 0; k < 3; k++) prv[k] = line_mem[j][k];
    line_end = (j >= ppl - 1);
    mesh_end = line_end && (i >= lpm - 1);

    if (i >= 1 && j >= 1) begin
      for (int k = 0; k < 3; k++) begin
        d1[k] = cur[k] - left_prev[k];
        d2[k] = left_cur[k] - prv[k];
      end
      csum = left_prev[0] + prv[0] + left_cur[0] + cur[0];
      p.cx = csum >>> 2;
      csum = left_prev[1] + prv[1] + left_cur[1] + cur[1];
      p.cy = csum >>> 2;
      csum = left_prev[2] + prv[2] + left_cur[2] + cur[2];
      p.cz = csum >>> 2;
      nv[0] = d1[1] * d2[2] - d1[2] * d2[1];
      nv[1] = d1[2] * d2[0] - d1[0] * d2[2];
      nv[2] = d1[0] * d2[1] - d1[1] * d2[0];
      sq = '0;
      for (int k = 0; k < 3; k++) begin
        mag = nv[k] < 0 ? -nv[k] : nv[k];
        sq += {64'd0, mag} * {64'd0, mag};
      end
      // bit-by-bit floor square root
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        trial = root | (128'd1 << b);
        if (trial * trial <= sq) root = trial;
      end
      for (int k = 0; k < 3; k++) begin
        q = '0;
        if (root != 0) begin
          mag = nv[k] < 0 ? -nv[k] : nv[k];
          neg = (nv[k] < 0) ^ reg_inv;
          num = mag << 14;
          q = num / root[63:0];
          if (neg) q = -q;
        end
        if (k == 0) p.nx = q[15:0];
        else if (k == 1) p.ny = q[15:0];
        else p.nz = q[15:0];
      end
      p.area = root[AreaW:1];
      if ({1'b0, area_sum} + {13'd0, p.area} > {1'b0, TotalCap}) area_sum = TotalCap;
      else area_sum = area_sum + p.area;
      p.total = area_sum;
      p.zero  = (sq == 0);
      p.row   = 16'(i - 1);
      p.col   = 10'(j - 1);
      p.last  = mesh_end;
      panel_q.push_back(p);
    end

    for (int k = 0; k < 3; k++) begin
      left_prev[k] = prv[k];
      left_cur[k]  = cur[k];
      line_mem[j][k] = cur[k];
    end
    if (mesh_end) begin
      pt_idx = 0; line_idx = 0; area_sum = '0;
    end else if (line_end) begin
      pt_idx = 0; line_idx = (i + 1) & 16'hFFFF;
    end else begin
      pt_idx = j + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued points, idling at random unless quiet.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (point_q.size() > 0 && (quiet || $urandom_range(99) >= 25)) begin
        in_if.valid   <= 1'b1;
        in_if.coord_x <= point_q[0].x;
        in_if.coord_y <= point_q[0].y;
        in_if.coord_z <= point_q[0].z;
        void'(point_q.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver ready: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_taken   <= 1'b0;
      hold_left    <= 0;
    end else if (hold_go && !hold_taken) begin
      hold_taken   <= 1'b1;
      hold_left    <= 2000;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= quiet || $urandom_range(99) >= 25;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on accepted points, checks accepted panels.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    point_t pt;
    panel_t e;
    if (rst_n && in_if.valid && in_if.ready) begin
      pt.x = in_if.coord_x;
      pt.y = in_if.coord_y;
      pt.z = in_if.coord_z;
      predict_point(pt);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (panel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: panel row %0d col %0d with none expected",
                   out_if.panel_row, out_if.panel_col);
      end else begin
        e = panel_q.pop_front();
        if (out_if.centroid_x !== e.cx || out_if.centroid_y !== e.cy ||
            out_if.centroid_z !== e.cz || out_if.normal_x !== e.nx ||
            out_if.normal_y !== e.ny || out_if.normal_z !== e.nz ||
            out_if.panel_area !== e.area || out_if.total_area !== e.total ||
            out_if.zero_area !== e.zero || out_if.panel_row !== e.row ||
            out_if.panel_col !== e.col || out_if.last_panel !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: panel row %0d col %0d", e.row, e.col);
            $display("  exp c=%0d,%0d,%0d n=%0d,%0d,%0d a=%0d t=%0d z=%0b r=%0d c=%0d l=%0b",
                     e.cx, e.cy, e.cz, e.nx, e.ny, e.nz, e.area, e.total,
                     e.zero, e.row, e.col, e.last);
            $display("  got c=%0d,%0d,%0d n=%0d,%0d,%0d a=%0d t=%0d z=%0b r=%0d c=%0d l=%0b",
                     out_if.centroid_x, out_if.centroid_y, out_if.centroid_z,
                     out_if.normal_x, out_if.normal_y, out_if.normal_z,
                     out_if.panel_area, out_if.total_area, out_if.zero_area,
                     out_if.panel_row, out_if.panel_col, out_if.last_panel);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value[15:0];
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_PPL: reg_ppl = value & 32'h7FF;
      CFG_LPM: reg_lpm = value & 32'hFFFF;
      default: reg_inv = value[0];
    endcase
  endtask

  // Blocks until the driver is empty and every predicted panel has come,
  // then lets a point that closes no panel finish inside the block.
  task automatic drain();
    while (point_q.size() > 0 || in_if.valid || panel_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_xyz(input longint x, input longint y, input longint z);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    point_q.push_back(p);
    sent++;
  endtask

  // style 0: full range, 1: small panels, 2: extremes, 3: repeated point
  function automatic longint rand_coord(input int style);
    case (style)
      0: return longint'($signed(24'($urandom)));
      1: return longint'($urandom_range(8192)) - 4096;
      2: return $urandom_range(1) ? CoordMax : CoordMin;
      default: return 0;
    endcase
  endfunction

  task automatic push_mesh_points(input int count, input int style);
    longint bx, by, bz;
    bx = rand_coord(0); by = rand_coord(0); bz = rand_coord(0);
    for (int n = 0; n < count; n++) begin
      if (style == 3 && $urandom_range(3) != 0) push_xyz(bx, by, bz);
      else if (style == 3) push_xyz(rand_coord(0), rand_coord(0), rand_coord(0));
      else push_xyz(rand_coord(style), rand_coord(style), rand_coord(style));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned ppl, lpm;
    in_if.valid   = 1'b0;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    in_if.coord_z = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_PPL;
    cfg_if.data   = '0;
    reg_ppl = 2; reg_lpm = 2; reg_inv = 1'b0;
    pt_idx = 0; line_idx = 0; area_sum = '0;
    for (int k = 0; k < 3; k++) begin
      left_cur[k] = 0; left_prev[k] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single-panel meshes at reset sizes.
    // flat unit square, normal along +z
    push_xyz(0, 0, 0); push_xyz(4096, 0, 0);
    push_xyz(0, 4096, 0); push_xyz(4096, 4096, 0);
    drain();
    // same square, inverted normal
    write_reg(CFG_INV, 1);
    push_xyz(0, 0, 0); push_xyz(4096, 0, 0);
    push_xyz(0, 4096, 0); push_xyz(4096, 4096, 0);
    drain();
    // out-of-range sizes clamp to 2x2; collapsed panel gives zero area
    write_reg(CFG_PPL, 0);
    write_reg(CFG_LPM, 1);
    write_reg(CFG_INV, 0);
    for (int n = 0; n < 4; n++) push_xyz(0, 0, 0);
    drain();
    // corners at the coordinate extremes
    push_xyz(CoordMin, CoordMin, CoordMin); push_xyz(CoordMax, CoordMin, CoordMin);
    push_xyz(CoordMin, CoordMax, CoordMax); push_xyz(CoordMax, CoordMax, CoordMax);
    drain();
    // negative centroid sums floor toward minus infinity
    write_reg(CFG_PPL, 1);
    push_xyz(-1, 0, 0); push_xyz(0, -2, 0);
    push_xyz(0, 0, -3); push_xyz(1, 1, 1);
    drain();

    // Longest line: 2047 clamps to the line store depth.
    write_reg(CFG_PPL, 2047);
    write_reg(CFG_LPM, 0);
    quiet = 1'b1;   // a stretch with no idling on either side
    push_mesh_points(MaxPts, 1);
    drain();
    // shorter second line closes the mesh after four points
    write_reg(CFG_PPL, 4);
    push_mesh_points(4, 1);
    drain();
    quiet = 1'b0;

    // Tallest mesh setting, cut short by lowering the line count.
    write_reg(CFG_PPL, 3);
    write_reg(CFG_LPM, 65535);
    write_reg(CFG_INV, 1);
    push_mesh_points(9, 0);
    drain();
    write_reg(CFG_LPM, 2);
    push_mesh_points(3, 0);
    drain();

    // Random meshes; counters sit at zero between them.
    for (int m = 0; sent < 1250; m++) begin
      ppl = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 6);
      lpm = $urandom_range(2, 6);
      write_reg(CFG_PPL, ppl);
      write_reg(CFG_LPM, lpm);
      write_reg(CFG_INV, $urandom_range(1));
      // one long receiver hold-off while the sender keeps pushing
      if (m == 0) hold_go = 1'b1;
      push_mesh_points(ppl * lpm, $urandom_range(5) < 3 ? 0 : $urandom_range(1, 3));
      // the sender waits for all panels before the next mesh
      drain();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && panel_q.size() == 0) begin
      $display("quad_mesh_panel_geometry test passed");
    end else begin
      $display("quad_mesh_panel_geometry test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
